/* rtl/core/p2p_pkg.sv */
// shared types and constants for the phonogram to phoneme text converter
package p2p_pkg;

  // character range bounds and offsets
  localparam logic [7:0] ChLo      = 8'h40;
  localparam logic [7:0] ChHi      = 8'h5b;
  localparam logic [7:0] Backquote = 8'd96;
  localparam logic [7:0] Apos      = 8'd39;
  localparam logic [7:0] CaseOfs   = 8'd32;

  // character codes the decoder looks at
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChComma  = 8'h2c;
  localparam logic [7:0] ChPeriod = 8'h2e;
  localparam logic [7:0] ChQuest  = 8'h3f;
  localparam logic [7:0] ChLBrack = 8'h5b;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChHyphen = 8'h2d;
  localparam logic [7:0] ChColon  = 8'h3a;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpC    = 8'h43;
  localparam logic [7:0] ChUpE    = 8'h45;
  localparam logic [7:0] ChUpH    = 8'h48;
  localparam logic [7:0] ChUpI    = 8'h49;
  localparam logic [7:0] ChUpO    = 8'h4f;
  localparam logic [7:0] ChUpQ    = 8'h51;
  localparam logic [7:0] ChUpU    = 8'h55;
  localparam logic [7:0] ChUpX    = 8'h58;
  localparam logic [7:0] ChLoG    = 8'h67;
  localparam logic [7:0] ChUpN    = 8'h4e;
  localparam logic [7:0] ChLoT    = 8'h74;
  localparam logic [7:0] ChLoY    = 8'h79;

  // most characters one item can produce
  localparam int unsigned MaxRun = 4;
  localparam int unsigned RunIdxW = $clog2(MaxRun);
  localparam int unsigned RunCntW = RunIdxW + 1;

  // queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAddrW = $clog2(QDepth);
  localparam int unsigned QCntW  = QAddrW + 1;

  // one item's worth of output characters
  typedef struct packed {
    logic [MaxRun-1:0][7:0] chars;
    logic [RunCntW-1:0]     count;
  } run_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* rtl/core/p2p_if.sv */
// handshake channels for phonogram input items and phoneme output items
interface p2p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cur_char;
  logic [7:0] next_char;
  logic [7:0] after_next_char;
  logic       phrase_start;
  logic       end_of_text;

  modport source (output valid, cur_char, next_char, after_next_char, phrase_start,
                  end_of_text, input ready);
  modport sink   (input valid, cur_char, next_char, after_next_char, phrase_start,
                  end_of_text, output ready);
endinterface

interface p2p_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;

  modport source (output valid, out_char, last_of_run, input ready);
  modport sink   (input valid, out_char, last_of_run, output ready);
endinterface

/* rtl/core/p2p_front.sv */
// front end: accepts items, decodes them into a run of output characters
module p2p_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  p2p_in_if.sink           in_ch,
  input  p2p_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output p2p_pkg::run_t    run_o
);
  import p2p_pkg::*;

  logic rise_q, rise_d;
  logic fall_q, fall_d;
  logic pause_q, pause_d;
  logic skip_q, skip_d;
  logic accept;
  run_t run;

  assign in_ch.ready = !q_stat_i.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // decode one item and update the accent and pause flags
  always_comb begin
    logic [RunCntW-1:0] n;
    logic [7:0]         c;
    logic [7:0]         nx;
    logic [7:0]         nn;
    logic               skipped;
    n       = '0;
    c       = in_ch.cur_char;
    nx      = in_ch.next_char;
    nn      = in_ch.after_next_char;
    skipped = 1'b0;
    run     = '0;
    rise_d  = rise_q;
    fall_d  = fall_q;
    pause_d = pause_q;
    skip_d  = skip_q;
    if (accept) begin
      if (skip_q) begin
        skip_d = 1'b0;
      end else begin
        if (in_ch.phrase_start && !pause_q) begin
          run.chars[n[RunIdxW-1:0]] = ChSpace;
          n = n + 1'b1;
        end
        unique case (c) inside
          ChLBrack, ChLParen: begin
            rise_d = 1'b1;
            fall_d = 1'b0;
          end
          ChSpace, ChComma, ChPeriod, ChQuest: begin
            run.chars[n[RunIdxW-1:0]] = c;
            n = n + 1'b1;
            pause_d = 1'b1;
          end
          Apos: begin
            if (fall_q) begin
              run.chars[n[RunIdxW-1:0]] = Backquote;
              n = n + 1'b1;
              fall_d = 1'b0;
            end
          end
          ChHyphen: begin
            run.chars[n[RunIdxW-1:0]] = ChColon;
            n = n + 1'b1;
            pause_d = 1'b0;
          end
          ChDollar: begin
            run.chars[n[RunIdxW-1:0]] = nx + CaseOfs;
            n = n + 1'b1;
            pause_d = 1'b0;
          end
          default: begin
            if (c > ChLo && c < ChHi) begin
              // accent opens on the first letter after a rise mark
              if (rise_q) begin
                run.chars[n[RunIdxW-1:0]] = Apos;
                n = n + 1'b1;
                rise_d = 1'b0;
                fall_d = 1'b1;
              end
              if (c == ChUpC) begin
                // ch plus vowel turns into t or ty, any other c drops out
                if (nx == ChUpH) begin
                  if (nn == ChUpI) begin
                    run.chars[n[RunIdxW-1:0]] = ChLoT;
                    n = n + 1'b1;
                    skipped = 1'b1;
                  end else if (nn == ChUpA || nn == ChUpU || nn == ChUpE ||
                               nn == ChUpO) begin
                    run.chars[n[RunIdxW-1:0]] = ChLoT;
                    n = n + 1'b1;
                    run.chars[n[RunIdxW-1:0]] = ChLoY;
                    n = n + 1'b1;
                    skipped = 1'b1;
                  end
                end
              end else if (c == ChUpQ) begin
                run.chars[n[RunIdxW-1:0]] = ChLoG;
                n = n + 1'b1;
              end else if (c == ChUpX) begin
                run.chars[n[RunIdxW-1:0]] = ChUpN;
                n = n + 1'b1;
              end else begin
                run.chars[n[RunIdxW-1:0]] = c + CaseOfs;
                n = n + 1'b1;
              end
              // after ch plus vowel mark the next item to be skipped, else close the accent before a closing paren
              if (skipped) begin
                skip_d = 1'b1;
              end else if (nx == ChRParen && fall_d) begin
                run.chars[n[RunIdxW-1:0]] = Backquote;
                n = n + 1'b1;
                fall_d = 1'b0;
              end
              pause_d = 1'b0;
            end
          end
        endcase
      end
      // end of text puts every flag back to its reset value
      if (in_ch.end_of_text) begin
        rise_d  = 1'b0;
        fall_d  = 1'b0;
        pause_d = 1'b1;
        skip_d  = 1'b0;
      end
    end
    run.count = n;
  end

  assign push_o = accept && (run.count != '0);
  assign run_o  = run;

  // flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q  <= 1'b0;
      fall_q  <= 1'b0;
      pause_q <= 1'b1;
      skip_q  <= 1'b0;
    end else begin
      rise_q  <= rise_d;
      fall_q  <= fall_d;
      pause_q <= pause_d;
      skip_q  <= skip_d;
    end
  end

  // the item after a ch-vowel conversion never produces characters
  a_skip_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && skip_q) |-> !push_o)
    else $error("skipped item produced characters");

endmodule

/* rtl/core/p2p_queue.sv */
// short queue of decoded runs between front and back
module p2p_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  p2p_pkg::run_t     run_i,
  input  logic              pop_i,
  output p2p_pkg::run_t     head_o,
  output p2p_pkg::q_stat_t  stat_o
);
  import p2p_pkg::*;

  run_t              mem_q [QDepth];
  logic [QAddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= run_i;
    end
  end

  // fill level
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from empty queue");

  a_run_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (run_i.count != '0))
    else $error("empty run pushed");

endmodule

/* rtl/core/p2p_back.sv */
// back end: sends the queued runs out one character per item
module p2p_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  p2p_pkg::run_t    head_i,
  input  p2p_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  p2p_out_if.source        out_ch
);
  import p2p_pkg::*;

  logic [RunIdxW-1:0] idx_q, idx_d;
  logic               vld_q, vld_d;
  logic [7:0]         char_q;
  logic               last_q;
  logic               load;
  logic               is_last;

  // output register takes a new character when empty or being drained
  assign load    = !vld_q || out_ch.ready;
  assign is_last = ({1'b0, idx_q} + 1'b1) == head_i.count;
  assign pop_o   = load && !q_stat_i.empty && is_last;

  // character index within the head run
  always_comb begin
    idx_d = idx_q;
    vld_d = vld_q;
    if (load) begin
      vld_d = !q_stat_i.empty;
      if (!q_stat_i.empty) begin
        idx_d = is_last ? '0 : idx_q + 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load && !q_stat_i.empty) begin
      char_q <= head_i.chars[idx_q];
      last_q <= is_last;
    end
  end

  assign out_ch.valid       = vld_q;
  assign out_ch.out_char    = char_q;
  assign out_ch.last_of_run = last_q;

  // the index never runs past the end of the head run
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_stat_i.empty |-> ({1'b0, idx_q} < head_i.count))
    else $error("character index beyond run length");

endmodule

/* rtl/core/phonogram_to_phoneme_text.sv */
// top level of the phonogram to phoneme text converter
// Converts one phonogram character per input item (with two characters of
// lookahead and a phrase-start flag) into zero to four phoneme-notation
// characters, each sent as its own output item with last_of_run marking the
// final character of an input. The front end decodes an item in the cycle it
// is accepted and can take one input item every cycle as long as its two-entry
// run queue has room; an input that yields nothing occupies no queue entry.
// The back end sends one character per cycle while the output is ready, so the
// sustained rate is set by that serializer: at most one output character per
// clock. Output is registered, and the run queue keeps the input side flowing
// while a result waits, until the queue is full.
module phonogram_to_phoneme_text (
  input  logic  clk_i,
  input  logic  rst_ni,
  p2p_in_if.sink    in_ch,
  p2p_out_if.source out_ch
);
  import p2p_pkg::*;

  logic    push;
  logic    pop;
  run_t    run;
  run_t    head;
  q_stat_t q_stat;

  p2p_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch    (in_ch),
    .q_stat_i (q_stat),
    .push_o   (push),
    .run_o    (run)
  );

  p2p_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .run_i  (run),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  p2p_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_ch   (out_ch)
  );

endmodule

/* tb/tb_top.sv */
// testbench for the phonogram to phoneme text converter, checked against a behavioral predictor
`timescale 1ns / 1ps

module tb_top;
  import p2p_pkg::*;

  // one input item as the predictor sees it
  typedef struct packed {
    logic [7:0] cur;
    logic [7:0] nxt;
    logic [7:0] nxt2;
    logic       ps;
    logic       eot;
  } phonogram_t;

  // one expected output character
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } phoneme_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  p2p_in_if  in_ch ();
  p2p_out_if out_ch ();

  phonogram_to_phoneme_text uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // predictor state, mirrors the block after reset
  logic rise_pend = 1'b0;
  logic fall_pend = 1'b0;
  logic pausing   = 1'b1;
  logic skip_h    = 1'b0;

  phoneme_t    phoneme_q [$];
  logic [7:0]  text_buf [$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  bit          calm_mode = 1'b0;

  // idle length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_mode) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(24, 4);
  endfunction

  task automatic report_fail(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic clear_phonogram_state();
    rise_pend = 1'b0;
    fall_pend = 1'b0;
    pausing   = 1'b1;
    skip_h    = 1'b0;
  endtask

  // compute the characters one accepted item produces and queue them
  task automatic predict_phonemes(input phonogram_t p);
    logic [7:0] run [$];
    logic       ch_done;
    phoneme_t   ph;
    ch_done = 1'b0;
    if (skip_h) begin
      skip_h = 1'b0;
    end else begin
      if (p.ps && !pausing) run.push_back(ChSpace);
      case (p.cur)
        ChLBrack, ChLParen: begin
          rise_pend = 1'b1;
          fall_pend = 1'b0;
        end
        ChSpace, ChComma, ChPeriod, ChQuest: begin
          run.push_back(p.cur);
          pausing = 1'b1;
        end
        Apos: begin
          if (fall_pend) begin
            run.push_back(Backquote);
            fall_pend = 1'b0;
          end
        end
        ChHyphen: begin
          run.push_back(ChColon);
          pausing = 1'b0;
        end
        ChDollar: begin
          run.push_back(p.nxt + CaseOfs);
          pausing = 1'b0;
        end
        default: begin
          if (p.cur > ChLo && p.cur < ChHi) begin
            // accent opens on the first letter after a rise
            if (rise_pend) begin
              run.push_back(Apos);
              rise_pend = 1'b0;
              fall_pend = 1'b1;
            end
            if (p.cur == ChUpC) begin
              // only ch plus a vowel produces anything
              if (p.nxt == ChUpH) begin
                if (p.nxt2 == ChUpI) begin
                  run.push_back(ChLoT);
                  ch_done = 1'b1;
                end else if (p.nxt2 == ChUpA || p.nxt2 == ChUpU || p.nxt2 == ChUpE ||
                             p.nxt2 == ChUpO) begin
                  run.push_back(ChLoT);
                  run.push_back(ChLoY);
                  ch_done = 1'b1;
                end
              end
            end else if (p.cur == ChUpQ) begin
              run.push_back(ChLoG);
            end else if (p.cur == ChUpX) begin
              run.push_back(ChUpN);
            end else begin
              run.push_back(p.cur + CaseOfs);
            end
            // closing paren ends the accent, unless the h is to be skipped
            if (ch_done) begin
              skip_h = 1'b1;
            end else if (p.nxt == ChRParen && fall_pend) begin
              run.push_back(Backquote);
              fall_pend = 1'b0;
            end
            pausing = 1'b0;
          end
        end
      endcase
    end
    foreach (run[i]) begin
      ph.ch   = run[i];
      ph.last = (i == run.size() - 1);
      phoneme_q.push_back(ph);
    end
    if (p.eot) clear_phonogram_state();
  endtask

  // drive one item, wait for acceptance, then predict
  task automatic send_char(input logic [7:0] cur, input logic [7:0] nxt,
                           input logic [7:0] nxt2, input logic ps, input logic eot);
    int unsigned gap;
    phonogram_t  p;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.cur_char        <= cur;
    in_ch.next_char       <= nxt;
    in_ch.after_next_char <= nxt2;
    in_ch.phrase_start    <= ps;
    in_ch.end_of_text     <= eot;
    do @(posedge clk_i); while (!in_ch.ready);
    p = '{cur: cur, nxt: nxt, nxt2: nxt2, ps: ps, eot: eot};
    predict_phonemes(p);
    items_sent++;
  endtask

  // send the text buffer with lookahead; the last character ends the text
  task automatic send_text(input logic [31:0] ps_mask, input bit ps_rand);
    int unsigned n;
    logic [7:0]  nxt;
    logic [7:0]  nxt2;
    logic        ps;
    n = text_buf.size();
    for (int i = 0; i < n; i++) begin
      nxt  = (i + 1 < n) ? text_buf[i + 1] : 8'h00;
      nxt2 = (i + 2 < n) ? text_buf[i + 2] : 8'h00;
      ps   = ps_rand ? ($urandom_range(4, 0) == 0) : ((i < 32) ? ps_mask[i] : 1'b0);
      send_char(text_buf[i], nxt, nxt2, ps, i == n - 1);
    end
  endtask

  function automatic void load_text(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  // random text: letters with ch groups, brackets, punctuation and occasional stray bytes
  function automatic void fill_random_phrase(input int unsigned len);
    string      vowels = "AIUEOK";
    string      pauses = " ,.?";
    string      others = "{}\"@";
    int unsigned r;
    text_buf.delete();
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99, 0);
      if (r < 8) begin
        text_buf.push_back(ChUpC);
        text_buf.push_back(ChUpH);
        text_buf.push_back(vowels[$urandom_range(5, 0)]);
      end else if (r < 14) begin
        text_buf.push_back($urandom_range(1, 0) ? ChLBrack : ChLParen);
      end else if (r < 19) begin
        text_buf.push_back($urandom_range(1, 0) ? ChRParen : 8'h5d);
      end else if (r < 24) begin
        text_buf.push_back(Apos);
      end else if (r < 32) begin
        text_buf.push_back(pauses[$urandom_range(3, 0)]);
      end else if (r < 35) begin
        text_buf.push_back(ChHyphen);
      end else if (r < 38) begin
        text_buf.push_back(ChDollar);
      end else if (r < 40) begin
        text_buf.push_back(others[$urandom_range(3, 0)]);
      end else begin
        text_buf.push_back(ChUpA + 8'($urandom_range(25, 0)));
      end
    end
  endfunction

  // bounds of the letter range, q and x, and the letter extremes
  task automatic test_letter_mapping();
    load_text("@AQXZ");
    send_text(32'h0, 1'b0);
  endtask

  // ch plus vowel forms, skipped h, rise and fall accents, four-character run
  task automatic test_ch_and_accents();
    load_text("A(CHA");
    send_text(32'hc, 1'b0);
    load_text("[CHI)");
    send_text(32'h0, 1'b0);
  endtask

  // punctuation, hyphen, apostrophe, lone c, dollar wrap and ignored bytes
  task automatic test_punctuation();
    load_text("[B'-C,?.");
    send_text(32'h20, 1'b0);
    send_char(ChDollar, 8'he5, 8'h00, 1'b0, 1'b0);
    send_char(8'hff, 8'hff, 8'hff, 1'b1, 1'b0);
    send_char(8'h00, 8'h00, 8'h00, 1'b1, 1'b1);
  endtask

  task automatic test_random_text(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      fill_random_phrase($urandom_range(20, 3));
      send_text(32'h0, 1'b1);
    end
  endtask

  // arbitrary bytes on every field
  task automatic test_noise(input int unsigned n_items);
    repeat (n_items) begin
      send_char(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                $urandom_range(7, 0) == 0);
    end
  endtask

  // no idling on either side, so the run queue fills up
  task automatic test_back_to_back(input int unsigned n_items);
    calm_mode = 1'b1;
    test_random_text(n_items);
    calm_mode = 1'b0;
  endtask

  // output side: random stalls
  initial begin
    int unsigned stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(3, 0) == 0) stall = pick_gap();
      end
    end
  end

  // compare each output item with the oldest expectation
  always @(posedge clk_i) begin
    phoneme_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (phoneme_q.size() == 0) begin
        report_fail($sformatf("unexpected item: out_char %h last_of_run %b",
                              out_ch.out_char, out_ch.last_of_run));
      end else begin
        want = phoneme_q.pop_front();
        if (out_ch.out_char !== want.ch || out_ch.last_of_run !== want.last)
          report_fail($sformatf("mismatch: out_char exp %h got %h, last_of_run exp %b got %b",
                                want.ch, out_ch.out_char, want.last, out_ch.last_of_run));
      end
    end
  end

  // stimulus sequence
  initial begin
    in_ch.valid           = 1'b0;
    in_ch.cur_char        = 8'h00;
    in_ch.next_char       = 8'h00;
    in_ch.after_next_char = 8'h00;
    in_ch.phrase_start    = 1'b0;
    in_ch.end_of_text     = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_letter_mapping();
    test_ch_and_accents();
    test_punctuation();
    test_random_text(280);
    test_noise(70);
    test_back_to_back(40);

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (phoneme_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (errors == 0 && phoneme_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
rtl/core/p2p_pkg.sv
rtl/core/p2p_if.sv
rtl/core/p2p_front.sv
rtl/core/p2p_queue.sv
rtl/core/p2p_back.sv
rtl/core/phonogram_to_phoneme_text.sv
tb/tb_top.sv
